FILE: rtl/vad_pkg.sv
// Package for the vector angle block: datapath widths, angle constants and
// the CORDIC arctangent table in degrees (Q.24). No dependencies.
package vad_pkg;

    // Differences of two Q24.8 coordinates are exact in 33 bits.
    localparam int CW = 33;
    // Folded coordinates need one bit more than the differences.
    localparam int DW = CW + 1;
    // Normalized magnitude width: the larger axis ends in [2^39, 2^40).
    localparam int MW = 40;
    // CORDIC x/y width, with headroom for the gain of about 1.65.
    localparam int XW = 44;
    // Angle accumulator, degrees in Q.24, covers +/-512 degrees.
    localparam int ZW = 34;
    // Result angle, degrees in Q9.16.
    localparam int AW = 25;

    localparam int CORDIC_STAGES_DEF = 20;
    localparam int CORDIC_STAGES_MAX = 32;

    localparam logic [15:0] DEAD_ZONE_RESET = 16'd3;

    localparam logic signed [AW-1:0] ANGLE_MAX = 25'sd11796480;
    localparam logic signed [AW-1:0] DEG90_Q16 = 25'sd5898240;
    localparam logic signed [ZW-1:0] DEG90_Q24 = 34'sd1509949440;

    // atan(2^-i) in degrees, Q.24.
    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:  r = 34'sd754974720;
            5'd1:  r = 34'sd445687602;
            5'd2:  r = 34'sd235489088;
            5'd3:  r = 34'sd119537938;
            5'd4:  r = 34'sd60000934;
            5'd5:  r = 34'sd30029717;
            5'd6:  r = 34'sd15018523;
            5'd7:  r = 34'sd7509720;
            5'd8:  r = 34'sd3754917;
            5'd9:  r = 34'sd1877466;
            5'd10: r = 34'sd938734;
            5'd11: r = 34'sd469367;
            5'd12: r = 34'sd234684;
            5'd13: r = 34'sd117342;
            5'd14: r = 34'sd58671;
            5'd15: r = 34'sd29335;
            5'd16: r = 34'sd14668;
            5'd17: r = 34'sd7334;
            5'd18: r = 34'sd3667;
            5'd19: r = 34'sd1833;
            5'd20: r = 34'sd917;
            5'd21: r = 34'sd458;
            5'd22: r = 34'sd229;
            5'd23: r = 34'sd115;
            5'd24: r = 34'sd57;
            5'd25: r = 34'sd29;
            5'd26: r = 34'sd14;
            5'd27: r = 34'sd7;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/vector_angle_degrees.sv
// Direction angle from a centre to a point, in degrees, by a pipelined CORDIC.
// Top level of the block; depends on vad_pkg for widths, constants and the
// arctangent table.
//
// Usage:
//   The input channel (s_valid / s_ready) carries one beat per point: the
//   centre and the point as signed Q24.8 coordinates. The result channel
//   (m_valid / m_ready) returns one beat per input beat, the angle of the
//   difference vector in signed Q9.16 degrees, within -180 to +180.
//   The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
//   dead zone, in 1/256 coordinate units; it is always ready and should be
//   written only while no point is in flight.
//   More than 32 stages count as 32. Throughput is one point per cycle
//   while the receiver takes results: the pipeline has four front stages
//   (difference, fold and zone test, two normalizing shift stages), one
//   stage per CORDIC rotation and an output register for rounding and
//   saturation.
//   Reset clears every valid bit and sets the dead zone to 3.
//   When the receiver stalls, the result waits in the output register and
//   the stages behind it keep filling bubbles; s_ready drops only once every
//   stage holds a point. No beat is lost or repeated.
module vector_angle_degrees
    import vad_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_centre_x,
    input  logic signed [31:0]   s_centre_y,
    input  logic signed [31:0]   s_point_x,
    input  logic signed [31:0]   s_point_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [AW-1:0] m_angle
);

    // Rotations actually built; more than the table holds acts as the table.
    localparam int NS = (CORDIC_STAGES > CORDIC_STAGES_MAX) ? CORDIC_STAGES_MAX
                                                            : CORDIC_STAGES;
    // Total register stages: four front stages, NS rotations, output.
    localparam int L  = NS + 5;
    localparam int RW = ZW + 1;

    localparam logic signed [RW-1:0] SAT_HI = RW'(ANGLE_MAX);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI;

    // ------------------------------------------------------------------
    // Configuration register. Writes never stall.
    // ------------------------------------------------------------------
    logic [15:0] dz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg <= DEAD_ZONE_RESET;
        end else if (cfg_valid) begin
            dz_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and the ready chain. A stage loads whenever it is empty
    // or the stage after it loads, so bubbles are squeezed out on a stall.
    // ------------------------------------------------------------------
    logic [L-1:0] vld_reg;
    logic [L-1:0] vld_in;
    logic [L:0]   en;

    assign en[L]  = m_ready;
    assign vld_in = {vld_reg[L-2:0], s_valid};

    for (genvar k = 0; k < L; k++) begin : g_ready
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < L; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[L-1];

    // ------------------------------------------------------------------
    // Stage 1: exact 33-bit differences.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] dx1_reg, dy1_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dx1_reg <= CW'(s_point_x) - CW'(s_centre_x);
            dy1_reg <= CW'(s_point_y) - CW'(s_centre_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dead-zone test, quadrant fold into the right half plane,
    // and the larger axis magnitude for normalization. The magnitude is the
    // same before and after the fold, which is a quarter turn.
    // ------------------------------------------------------------------
    logic                 byp2_reg;
    logic signed [AW-1:0] bang2_reg;
    logic signed [DW-1:0] fx2_reg, fy2_reg;
    logic signed [ZW-1:0] fz2_reg;
    logic [CW-1:0]        m2_reg;

    logic                 dx_neg, dy_neg, dy_pos, zx, zy;
    logic [CW-1:0]        mag_dx, mag_dy;
    logic signed [DW-1:0] dxe, dye;
    logic                 byp2_next;
    logic signed [AW-1:0] bang2_next;
    logic signed [DW-1:0] fx2_next, fy2_next;
    logic signed [ZW-1:0] fz2_next;

    always_comb begin
        dx_neg = dx1_reg[CW-1];
        dy_neg = dy1_reg[CW-1];
        dy_pos = !dy_neg && (dy1_reg != '0);
        mag_dx = dx_neg ? CW'(-dx1_reg) : CW'(dx1_reg);
        mag_dy = dy_neg ? CW'(-dy1_reg) : CW'(dy1_reg);
        zx     = (mag_dx == '0) || (mag_dx < CW'(dz_reg));
        zy     = (mag_dy == '0) || (mag_dy < CW'(dz_reg));
        dxe    = DW'(dx1_reg);
        dye    = DW'(dy1_reg);

        byp2_next = zx || zy;
        if (zx && zy) begin
            bang2_next = '0;
        end else if (zx) begin
            bang2_next = dy_neg ? -DEG90_Q16 : DEG90_Q16;
        end else begin
            bang2_next = dx_neg ? ANGLE_MAX : '0;
        end

        if (dx_neg && dy_pos) begin
            fx2_next = dye;
            fy2_next = -dxe;
            fz2_next = DEG90_Q24;
        end else if (dx_neg) begin
            fx2_next = -dye;
            fy2_next = dxe;
            fz2_next = -DEG90_Q24;
        end else begin
            fx2_next = dxe;
            fy2_next = dye;
            fz2_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            byp2_reg  <= byp2_next;
            bang2_reg <= bang2_next;
            fx2_reg   <= fx2_next;
            fy2_reg   <= fy2_next;
            fz2_reg   <= fz2_next;
            m2_reg    <= (mag_dx > mag_dy) ? mag_dx : mag_dy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: coarse normalizing shifts by 32, 16 and 8. Each step shifts
    // when the top bits it would push out of the magnitude are all zero.
    // ------------------------------------------------------------------
    logic                 byp3_reg;
    logic signed [AW-1:0] bang3_reg;
    logic signed [XW-1:0] nx3_reg, ny3_reg;
    logic signed [ZW-1:0] nz3_reg;
    logic [MW-1:0]        m3_reg;

    logic [MW-1:0]        m3_next;
    logic signed [XW-1:0] nx3_next, ny3_next;

    always_comb begin
        m3_next  = MW'(m2_reg);
        nx3_next = XW'(fx2_reg);
        ny3_next = XW'(fy2_reg);
        if (m3_next[MW-1 -: 32] == '0) begin
            m3_next  = m3_next << 32;
            nx3_next = nx3_next <<< 32;
            ny3_next = ny3_next <<< 32;
        end
        if (m3_next[MW-1 -: 16] == '0) begin
            m3_next  = m3_next << 16;
            nx3_next = nx3_next <<< 16;
            ny3_next = ny3_next <<< 16;
        end
        if (m3_next[MW-1 -: 8] == '0) begin
            m3_next  = m3_next << 8;
            nx3_next = nx3_next <<< 8;
            ny3_next = ny3_next <<< 8;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            byp3_reg  <= byp2_reg;
            bang3_reg <= bang2_reg;
            nx3_reg   <= nx3_next;
            ny3_reg   <= ny3_next;
            nz3_reg   <= fz2_reg;
            m3_reg    <= m3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: fine normalizing shifts by 4, 2 and 1. Its registers are
    // the input of the first rotation.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx_reg [0:NS];
    logic signed [XW-1:0] cy_reg [0:NS];
    logic signed [ZW-1:0] cz_reg [0:NS];
    logic                 cb_reg [0:NS];
    logic signed [AW-1:0] ca_reg [0:NS];

    logic [MW-1:0]        m4;
    logic signed [XW-1:0] nx4, ny4;

    always_comb begin
        m4  = m3_reg;
        nx4 = nx3_reg;
        ny4 = ny3_reg;
        if (m4[MW-1 -: 4] == '0) begin
            m4  = m4 << 4;
            nx4 = nx4 <<< 4;
            ny4 = ny4 <<< 4;
        end
        if (m4[MW-1 -: 2] == '0) begin
            m4  = m4 << 2;
            nx4 = nx4 <<< 2;
            ny4 = ny4 <<< 2;
        end
        if (!m4[MW-1]) begin
            nx4 = nx4 <<< 1;
            ny4 = ny4 <<< 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            cx_reg[0] <= nx4;
            cy_reg[0] <= ny4;
            cz_reg[0] <= nz3_reg;
            cb_reg[0] <= byp3_reg;
            ca_reg[0] <= bang3_reg;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotations in vectoring mode, one register stage each. The
    // sign of y picks the direction that drives y toward zero.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NS; i++) begin : g_rot
        localparam logic signed [ZW-1:0] ATAN_I = atan_deg(5'(i));

        always_ff @(posedge aclk) begin
            if (en[4+i]) begin
                if (!cy_reg[i][XW-1]) begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + ATAN_I;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - ATAN_I;
                end
                cb_reg[i+1] <= cb_reg[i];
                ca_reg[i+1] <= ca_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: round Q.24 half up to Q.16, saturate to +/-180
    // degrees, or pass the dead-zone answer.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] angle_reg;
    logic signed [RW-1:0] rsum, rq;
    logic signed [AW-1:0] angle_next;

    always_comb begin
        rsum = RW'(cz_reg[NS]) + RW'(128);
        rq   = rsum >>> 8;
        if (cb_reg[NS]) begin
            angle_next = ca_reg[NS];
        end else if (rq > SAT_HI) begin
            angle_next = ANGLE_MAX;
        end else if (rq < SAT_LO) begin
            angle_next = -ANGLE_MAX;
        end else begin
            angle_next = AW'(rq);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[L-1]) begin
            angle_reg <= angle_next;
        end
    end

    assign m_angle = angle_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The result always lies within -180 to +180 degrees.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle <= ANGLE_MAX) && (m_angle >= -ANGLE_MAX))
        else $error("angle out of range");

    // The input is refused only when every stage holds a point.
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A stalled first stage keeps its differences.
    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[0] && !en[1]) |=> (vld_reg[0] && $stable(dx1_reg) && $stable(dy1_reg)))
        else $error("first stage changed while stalled");

    // After folding and normalization, x stays positive through the rotations.
    a_x_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[L-2] && !cb_reg[NS]) |-> (cx_reg[NS] > 0))
        else $error("CORDIC x went non-positive");

endmodule
